FILE: hw/rtl/tnseg_pkg.sv
`timescale 1ns / 1ps

package tnseg_pkg;

  // Display modes carried down the pipeline.
  localparam logic [1:0] ModeNum = 2'd0;
  localparam logic [1:0] ModeHi  = 2'd1;
  localparam logic [1:0] ModeLo  = 2'd2;

  // Range limits, in tenths.
  localparam logic signed [15:0] HiLimit    = 16'sd19995;
  localparam logic signed [15:0] LoLimit    = -16'sd995;
  localparam logic signed [15:0] PointHigh  = 16'sd1995;
  localparam logic signed [15:0] PointLow   = -16'sd95;
  localparam logic [10:0]        LeadLimit  = 11'd999;
  localparam logic [10:0]        HundLimit  = 11'd99;

  // Reciprocals: x * RecipTen >> RecipTenShift is x / 10 for x below 43690.
  // x * RecipHund >> RecipHundShift is x / 100 for x up to 2000.
  localparam logic [31:0] RecipTen       = 32'd52429;
  localparam int unsigned RecipTenShift  = 19;
  localparam logic [31:0] RecipHund      = 32'd1311;
  localparam int unsigned RecipHundShift = 17;

  // Fixed patterns for out-of-range values.
  localparam logic [7:0] HiByte8  = 8'h10;
  localparam logic [7:0] HiByte9  = 8'h09;
  localparam logic [7:0] HiByte10 = 8'hC3;
  localparam logic [7:0] HiByte11 = 8'hF0;
  localparam logic [7:0] LoByte8  = 8'h30;
  localparam logic [7:0] LoByte9  = 8'h39;
  localparam logic [7:0] LoByte10 = 8'h38;
  localparam logic [7:0] LoByte11 = 8'hE0;
  localparam logic [7:0] MinusSeg = 8'h40;
  localparam logic [7:0] PointSeg = 8'h10;

  // Stage 1: classified value and magnitude before rounding.
  typedef struct packed {
    logic [1:0]  mode;
    logic        neg;
    logic        point;
    logic [14:0] mag;
  } front_t;

  // Stage 2: magnitude as shown on the panel, at most 2000 in numeric mode.
  typedef struct packed {
    logic [1:0]  mode;
    logic        neg;
    logic        point;
    logic [10:0] mag;
  } round_t;

  // Stage 3: magnitude with its quotients by ten and by one hundred.
  typedef struct packed {
    logic [1:0]  mode;
    logic        neg;
    logic        point;
    logic [10:0] mag;
    logic [7:0]  q10;
    logic [4:0]  q100;
  } split_t;

  // Stage 4: the panel bytes.
  typedef struct packed {
    logic [7:0] b8;
    logic [7:0] b9;
    logic [7:0] b10;
    logic [7:0] b11;
    logic [7:0] b12;
    logic [7:0] b13;
    logic       lead;
  } seg_t;

  function automatic logic [7:0] dig_left(input logic [3:0] d);
    logic [7:0] r;
    case (d)
      4'd0:    r = 8'hBF;
      4'd1:    r = 8'h00;
      4'd2:    r = 8'hF7;
      4'd3:    r = 8'hF1;
      4'd4:    r = 8'h5C;
      4'd5:    r = 8'hFD;
      4'd6:    r = 8'hFF;
      4'd7:    r = 8'h90;
      4'd8:    r = 8'hFF;
      4'd9:    r = 8'hFD;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] dig_right(input logic [3:0] d);
    logic [7:0] r;
    case (d)
      4'd0, 4'd1, 4'd3, 4'd4, 4'd7, 4'd8, 4'd9: r = 8'h07;
      4'd2:    r = 8'h06;
      4'd5:    r = 8'h03;
      4'd6:    r = 8'h03;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

FILE: hw/rtl/tnseg_front.sv
`timescale 1ns / 1ps

// Two stages: classify and take the magnitude, then round to whole units outside the point range.
module tnseg_front import tnseg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic signed [15:0] value_i,
  output logic               valid_o,
  input  logic               ready_i,
  output round_t             data_o
);

  logic        s1_valid_q;
  front_t      s1_q, s1_d;
  logic        s1_ready;
  logic        s2_valid_q;
  round_t      s2_q, s2_d;
  logic        s2_ready;
  logic signed [16:0] ext;
  logic [16:0] abs_val;
  logic [15:0] sum;
  logic [31:0] prod;

  always_comb begin
    ext      = 17'(value_i);
    abs_val  = ext[16] ? 17'(-ext) : 17'(ext);
    s1_d.neg   = value_i[15];
    s1_d.point = (value_i <= PointHigh) && (value_i >= PointLow);
    s1_d.mag   = abs_val[14:0];
    if (value_i > HiLimit) begin
      s1_d.mode = ModeHi;
    end else if (value_i < LoLimit) begin
      s1_d.mode = ModeLo;
    end else begin
      s1_d.mode = ModeNum;
    end
  end

  always_comb begin
    sum  = 16'(s1_q.mag) + 16'd5;
    prod = 32'(sum) * RecipTen;
    s2_d.mode  = s1_q.mode;
    s2_d.neg   = s1_q.neg;
    s2_d.point = s1_q.point;
    if (s1_q.point) begin
      s2_d.mag = s1_q.mag[10:0];
    end else begin
      s2_d.mag = 11'(prod >> RecipTenShift);
    end
  end

  assign s2_ready = !s2_valid_q || ready_i;
  assign s1_ready = !s1_valid_q || s2_ready;
  assign ready_o  = s1_ready;
  assign valid_o  = s2_valid_q;
  assign data_o   = s2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= valid_i;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && valid_i) begin
      s1_q <= s1_d;
    end
    if (s2_ready && s1_valid_q) begin
      s2_q <= s2_d;
    end
  end

endmodule

FILE: hw/rtl/tnseg_split.sv
`timescale 1ns / 1ps

// Quotients of the shown magnitude by ten and by one hundred.
module tnseg_split import tnseg_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  output logic   ready_o,
  input  round_t data_i,
  output logic   valid_o,
  input  logic   ready_i,
  output split_t data_o
);

  logic        valid_q;
  split_t      data_q, data_d;
  logic [31:0] p10;
  logic [31:0] p100;

  always_comb begin
    p10  = 32'(data_i.mag) * RecipTen;
    p100 = 32'(data_i.mag) * RecipHund;
    data_d.mode  = data_i.mode;
    data_d.neg   = data_i.neg;
    data_d.point = data_i.point;
    data_d.mag   = data_i.mag;
    data_d.q10   = 8'(p10 >> RecipTenShift);
    data_d.q100  = 5'(p100 >> RecipHundShift);
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

FILE: hw/rtl/tnseg_encode.sv
`timescale 1ns / 1ps

// Digit extraction and segment lookup; this is the output register.
module tnseg_encode import tnseg_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  output logic   ready_o,
  input  split_t data_i,
  output logic   valid_o,
  input  logic   ready_i,
  output seg_t   data_o
);

  logic        valid_q;
  seg_t        data_q, data_d;
  logic [3:0]  ones;
  logic [3:0]  tens;
  logic [3:0]  hund;
  logic [10:0] ones_w;
  logic [7:0]  tens_w;

  always_comb begin
    ones_w = data_i.mag - 11'(data_i.q10) * 11'd10;
    tens_w = data_i.q10 - 8'(data_i.q100) * 8'd10;
    ones   = ones_w[3:0];
    tens   = tens_w[3:0];
    if (data_i.q100 >= 5'd20) begin
      hund = 4'(data_i.q100 - 5'd20);
    end else if (data_i.q100 >= 5'd10) begin
      hund = 4'(data_i.q100 - 5'd10);
    end else begin
      hund = data_i.q100[3:0];
    end

    data_d = '0;
    case (data_i.mode)
      ModeHi: begin
        data_d.b8  = HiByte8;
        data_d.b9  = HiByte9;
        data_d.b10 = HiByte10;
        data_d.b11 = HiByte11;
      end
      ModeLo: begin
        data_d.b8  = LoByte8;
        data_d.b9  = LoByte9;
        data_d.b10 = LoByte10;
        data_d.b11 = LoByte11;
      end
      default: begin
        // The minus sign and a hundreds digit share byte 8 and are ORed.
        if (data_i.neg) begin
          data_d.b8 = MinusSeg;
        end
        if (data_i.mag > HundLimit) begin
          data_d.b8 = data_d.b8 | dig_left(hund);
          data_d.b9 = dig_right(hund);
        end
        // Below ten the tens quotient is zero, which gives the forced zero.
        data_d.b10  = dig_left(tens);
        data_d.b11  = dig_right(tens) | (data_i.point ? PointSeg : 8'h00);
        data_d.b12  = dig_left(ones);
        data_d.b13  = dig_right(ones);
        data_d.lead = data_i.mag > LeadLimit;
      end
    endcase
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

FILE: hw/rtl/tenths_number_to_segments.sv
`timescale 1ns / 1ps

// Channel  | Direction | Handshake                 | Payload
// ---------+-----------+---------------------------+-------------------------------------
// input    | in        | in_valid_i / in_ready_o   | value_tenths_i (16 bit, signed)
// output   | out       | out_valid_o / out_ready_i | seg_byte8_o .. seg_byte13_o, leading_one_o
//
// One request is taken every cycle while in_ready_o is high; each result passes through the
// four register stages in order: classify, round, divide, encode.
// Reset clears only the valid bits of the stages; the pipeline is empty afterwards.
// When the output is stalled, each stage holds its item only while the stage after it
// is full, so empty slots close up and no request is lost or repeated.
// in_ready_o falls only when all four stages hold items and the output is stalled.
module tenths_number_to_segments import tnseg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] value_tenths_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         seg_byte8_o,
  output logic [7:0]         seg_byte9_o,
  output logic [7:0]         seg_byte10_o,
  output logic [7:0]         seg_byte11_o,
  output logic [7:0]         seg_byte12_o,
  output logic [7:0]         seg_byte13_o,
  output logic               leading_one_o
);

  logic   round_valid;
  logic   round_ready;
  round_t round_data;
  logic   split_valid;
  logic   split_ready;
  split_t split_data;
  seg_t   seg_data;

  // Stages one and two: range check, magnitude, and rounding to whole units.
  tnseg_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .value_i (value_tenths_i),
    .valid_o (round_valid),
    .ready_i (round_ready),
    .data_o  (round_data)
  );

  // Stage three: quotients by ten and one hundred through reciprocal multiplies.
  tnseg_split u_split (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (round_valid),
    .ready_o (round_ready),
    .data_i  (round_data),
    .valid_o (split_valid),
    .ready_i (split_ready),
    .data_o  (split_data)
  );

  // Stage four: digits, segment tables, and the output register.
  tnseg_encode u_encode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (split_valid),
    .ready_o (split_ready),
    .data_i  (split_data),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (seg_data)
  );

  assign seg_byte8_o   = seg_data.b8;
  assign seg_byte9_o   = seg_data.b9;
  assign seg_byte10_o  = seg_data.b10;
  assign seg_byte11_o  = seg_data.b11;
  assign seg_byte12_o  = seg_data.b12;
  assign seg_byte13_o  = seg_data.b13;
  assign leading_one_o = seg_data.lead;

`ifndef SYNTHESIS
  // A number always shows a ones digit, whose right side is never blank.
  a_blank_right_is_pattern: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (seg_byte13_o == 8'h00) |-> (seg_byte12_o == 8'h00) && !leading_one_o)
    else $error("right digit blank on a numeric result");

  // A leading one implies a hundreds digit on the left.
  a_lead_has_hundreds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && leading_one_o |-> (seg_byte9_o != 8'h00))
    else $error("leading one without hundreds digit");

  // The pipeline can be full only when the output side is stalled.
  a_ready_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i && split_valid && round_valid)
    else $error("input stalled while pipeline has room");

  // When the encode stage takes an item from the divide stage, it is valid at the output in the next cycle.
  a_split_feeds_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    split_valid && split_ready |=> out_valid_o)
    else $error("item lost between divide and encode stages");
`endif

endmodule
